### rtl/rusf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rusf_pkg
// shared types, codes and constants of the unpremultiplying scanline former
// ----------------------------------------------------------------------------
package rusf_pkg;

  // filter type byte that opens every row
  localparam logic [7:0] FILTER_NONE = 8'd0;
  // fully opaque alpha, colors pass untouched
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR = 8'd0;

  // configuration register indexes
  localparam logic [1:0] CFG_ROW_PIXELS = 2'd0;
  localparam logic [1:0] CFG_ROW_TOTAL = 2'd1;
  localparam logic [1:0] CFG_HAS_ALPHA = 2'd2;

  // color component indexes
  localparam logic [1:0] COMP_RED = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE = 2'd2;

  // index of the last divider step of a quotient
  localparam logic [2:0] DIV_LAST_STEP = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rusf_pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       pixel_last;
    logic       image_last;
  } rusf_stream_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILTER,
    S_PREP,
    S_DIV,
    S_EMIT,
    S_ALPHA
  } rusf_state_t;

  typedef enum logic [1:0] {
    SEL_FILTER,
    SEL_COMP,
    SEL_ALPHA
  } rusf_sel_t;

  typedef struct packed {
    logic      take;
    logic      div_start;
    logic      div_step;
    logic      emit;
    rusf_sel_t sel;
    logic      comp_next;
  } rusf_cmd_t;

  typedef struct packed {
    logic drop;
    logic first_col;
    logic need_div;
    logic alpha_mode;
    logic comp_last;
    logic div_done;
    logic out_free;
  } rusf_status_t;

endpackage : rusf_pkg
`default_nettype wire

### rtl/rusf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rusf_ctrl
// sequencer: filter byte, per-component divide and emit, alpha byte
// ----------------------------------------------------------------------------
module rusf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pixel_valid,
  output logic                       pixel_stall,
  input  wire rusf_pkg::rusf_status_t st,
  output rusf_pkg::rusf_cmd_t        cmd
);
  import rusf_pkg::*;

  rusf_state_t state;
  rusf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.sel = SEL_FILTER;
    pixel_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (pixel_valid) begin
          cmd.take = 1'b1;
          if (!st.drop) begin
            state_next = st.first_col ? S_FILTER : S_PREP;
          end
        end
      end
      S_FILTER: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = SEL_FILTER;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        state_next = st.need_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = SEL_COMP;
          if (st.comp_last) begin
            state_next = st.alpha_mode ? S_ALPHA : S_IDLE;
          end else begin
            cmd.comp_next = 1'b1;
            state_next = S_PREP;
          end
        end
      end
      S_ALPHA: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = SEL_ALPHA;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule : rusf_ctrl
`default_nettype wire

### rtl/rusf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rusf_dpath
// config registers, position counters, pixel latch, radix-2 divider and
// output register
// ----------------------------------------------------------------------------
module rusf_dpath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire rusf_pkg::rusf_pixel_t pixel_data,
  input  wire rusf_pkg::rusf_cmd_t   cmd,
  output rusf_pkg::rusf_status_t     st,
  output logic                       stream_valid,
  output rusf_pkg::rusf_stream_t     stream_data,
  input  wire logic                  stream_stall
);
  import rusf_pkg::*;

  // configuration
  logic [15:0] row_pixels;
  logic [15:0] row_total;
  logic        has_alpha;

  // position
  logic [15:0] column_pos;
  logic [15:0] row_pos;
  logic        image_done;

  // current pixel
  rusf_pixel_t pix;
  logic        alpha_mode;
  logic        need_div;
  logic        img_end;
  logic [1:0]  comp_idx;

  // divider
  logic [7:0]  rem;
  logic [7:0]  dvd;
  logic [7:0]  quo;
  logic [2:0]  div_cnt;

  logic [16:0] col_inc;
  logic        row_end;
  logic [15:0] row_inc;
  logic [7:0]  comp_raw;
  logic [7:0]  comp_clamp;
  logic [15:0] prod;
  logic [8:0]  trial;
  logic        trial_ge;
  logic        last;
  logic [7:0]  emit_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pixels <= 16'd1;
      row_total <= 16'd1;
      has_alpha <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_PIXELS: row_pixels <= cfg_data;
        CFG_ROW_TOTAL:  row_total <= cfg_data;
        CFG_HAS_ALPHA:  has_alpha <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // position update for an accepted pixel
  always_comb begin
    col_inc = {1'b0, column_pos} + 17'd1;
    row_end = (col_inc >= {1'b0, row_pixels});
    row_inc = row_pos + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos <= '0;
      image_done <= 1'b0;
      img_end <= 1'b0;
    end else if (cmd.take) begin
      if (st.drop) begin
        image_done <= 1'b1;
      end else if (row_end) begin
        column_pos <= '0;
        row_pos <= row_inc;
        img_end <= (row_inc >= row_total);
        if (row_inc >= row_total) begin
          image_done <= 1'b1;
        end
      end else begin
        column_pos <= col_inc[15:0];
        img_end <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix <= pixel_data;
      alpha_mode <= has_alpha;
      need_div <= has_alpha && (pixel_data.alpha != ALPHA_CLEAR)
                  && (pixel_data.alpha != ALPHA_OPAQUE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_idx <= COMP_RED;
    end else if (cmd.take) begin
      comp_idx <= COMP_RED;
    end else if (cmd.comp_next) begin
      comp_idx <= comp_idx + 2'd1;
    end
  end

  always_comb begin
    case (comp_idx)
      COMP_RED:   comp_raw = pix.red;
      COMP_GREEN: comp_raw = pix.green;
      default:    comp_raw = pix.blue;
    endcase
    comp_clamp = (comp_raw > pix.alpha) ? pix.alpha : comp_raw;
    // c * 255 without a multiplier
    prod = {comp_clamp, 8'd0} - {8'd0, comp_clamp};
    trial = {rem, dvd[7]};
    trial_ge = (trial >= {1'b0, pix.alpha});
  end

  // restoring divide, one quotient bit per cycle; high byte of c*255 is
  // already below alpha so eight steps give the whole quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= prod[15:8];
      dvd <= prod[7:0];
    end else if (cmd.div_step) begin
      rem <= trial_ge ? 8'(trial - {1'b0, pix.alpha}) : trial[7:0];
      dvd <= {dvd[6:0], 1'b0};
      quo <= {quo[6:0], trial_ge};
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_FILTER: begin
        emit_byte = FILTER_NONE;
        last = 1'b0;
      end
      SEL_COMP: begin
        emit_byte = need_div ? quo : comp_raw;
        last = !alpha_mode && (comp_idx == COMP_BLUE);
      end
      SEL_ALPHA: begin
        emit_byte = pix.alpha;
        last = 1'b1;
      end
      default: begin
        emit_byte = FILTER_NONE;
        last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_valid <= 1'b0;
    end else if (cmd.emit) begin
      stream_valid <= 1'b1;
    end else if (!stream_stall) begin
      stream_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      stream_data.out_byte <= emit_byte;
      stream_data.pixel_last <= last;
      stream_data.image_last <= last && img_end;
    end
  end

  always_comb begin
    st.drop = image_done || (row_pos >= row_total);
    st.first_col = (column_pos == 16'd0);
    st.need_div = need_div;
    st.alpha_mode = alpha_mode;
    st.comp_last = (comp_idx == COMP_BLUE);
    st.div_done = (div_cnt == DIV_LAST_STEP);
    st.out_free = !stream_valid || !stream_stall;
  end

endmodule : rusf_dpath
`default_nettype wire

### rtl/rgba_unpremultiply_scanline_former_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_unpremultiply_scanline_former_core
// turns raster-order pixels into the byte stream of unfiltered png scanlines,
// converting premultiplied rgba to straight alpha
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 beat
//  pixel     in   pixel_valid/pixel_stall   red, green, blue, alpha
//  stream    out  stream_valid/stream_stall out_byte, pixel_last, image_last
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  one pixel at a time: accept, optional filter byte, then per color a load
//  step, a restoring divide (only for rgba pixels whose alpha is not 0 or
//  255) and an emit step, then the alpha byte when alpha is on; the
//  divider's loop gives one quotient bit per cycle
//  every emit waits for the output register to be free, so stream_stall
//  holds the sequencer in place
//  dropped pixels (past the last row) are taken with no beats
//  rst is synchronous; config and counters return to their reset values
// ----------------------------------------------------------------------------
module rgba_unpremultiply_scanline_former_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // pixel input
  input  wire logic                   pixel_valid,
  output logic                        pixel_stall,
  input  wire rusf_pkg::rusf_pixel_t  pixel_data,
  // byte stream output
  output logic                        stream_valid,
  input  wire logic                   stream_stall,
  output rusf_pkg::rusf_stream_t      stream_data,
  // config writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);
  import rusf_pkg::*;

  rusf_cmd_t    cmd;
  rusf_status_t st;
  logic         cfg_we;

  // config is only to be written while idle (the user's duty, not enforced here), so it is always taken
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  // sequencer
  rusf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .st          (st),
    .cmd         (cmd)
  );

  // counters, divider and output register
  rusf_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_data   (pixel_data),
    .cmd          (cmd),
    .st           (st),
    .stream_valid (stream_valid),
    .stream_data  (stream_data),
    .stream_stall (stream_stall)
  );

endmodule : rgba_unpremultiply_scanline_former_core
`default_nettype wire

### rtl/rusf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rusf_checker
// port-level checks on the scanline former, bound to the top level
// ----------------------------------------------------------------------------
module rusf_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   pixel_valid,
  input wire logic                   pixel_stall,
  input wire logic                   stream_valid,
  input wire logic                   stream_stall,
  input wire rusf_pkg::rusf_stream_t stream_data
);
  import rusf_pkg::*;

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !stream_valid)
    else $error("stream beat valid right after reset");

  // a stalled beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    stream_valid && stream_stall |=> stream_valid && $stable(stream_data))
    else $error("stalled stream beat changed");

  // the input only closes after a pixel was taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_stall) |-> $past(pixel_valid))
    else $error("pixel input stalled with no pixel taken");

  // beats only start while a pixel is being worked on
  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    $rose(stream_valid) |-> $past(pixel_stall))
    else $error("stream beat with no pixel in flight");

  // end of image is always the end of a pixel
  a_last_nesting: assert property (@(posedge clk) disable iff (rst)
    stream_valid && stream_data.image_last |-> stream_data.pixel_last)
    else $error("image_last without pixel_last");

endmodule : rusf_checker

bind rgba_unpremultiply_scanline_former_core rusf_checker u_rusf_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .stream_valid (stream_valid),
  .stream_stall (stream_stall),
  .stream_data  (stream_data)
);
`default_nettype wire
